### hdl/fpam_pkg.sv
// shared types, constants and helpers for the flash page address mapper
// used by fpam_div and flash_page_address_mapper; no dependencies
package fpam_pkg;

  // default geometry limits
  localparam int MAX_STACKS_DEF = 16;
  localparam int MAX_BLOCKS_DEF = 65536;
  localparam int MAX_PAGES_DEF  = 4096;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP = 2;

  // widths of the request and result fields
  localparam int LPN_W   = 48;
  localparam int STACK_W = 4;
  localparam int DIE_W   = 4;
  localparam int PLANE_W = 3;
  localparam int BLOCK_W = 16;
  localparam int PAGE_W  = 12;
  localparam int PORT_W  = 4;
  localparam int RADIX_W = 17;
  localparam int FLAT_W  = 12;
  localparam int NPORT_W = 5;
  localparam int ADDR_W  = 5;

  typedef enum logic [1:0] {
    MODE_LINEAR     = 2'd0,
    MODE_BURST      = 2'd1,
    MODE_INTERLEAVE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_STACKS = 3'd1,
    REG_DIES   = 3'd2,
    REG_PLANES = 3'd3,
    REG_BLOCKS = 3'd4,
    REG_PAGES  = 3'd5,
    REG_PORTS  = 3'd6,
    REG_SLICES = 3'd7
  } reg_e;

  // request data and digit remainders that ride along the divider chain
  typedef struct packed {
    logic [LPN_W-1:0]   lpn;
    logic [RADIX_W-1:0] r5;
    logic [RADIX_W-1:0] r4;
    logic [RADIX_W-1:0] r3;
    logic [RADIX_W-1:0] r2;
    logic [RADIX_W-1:0] r1;
  } side_t;

  // decoded location that rides along the port divider
  typedef struct packed {
    logic [LPN_W-1:0]   lpn;
    logic [STACK_W-1:0] st;
    logic [DIE_W-1:0]   di;
    logic [PLANE_W-1:0] pl;
    logic [BLOCK_W-1:0] bl;
    logic [PAGE_W-1:0]  pg;
  } loc_t;

  // zero reads as one, anything above the bound saturates
  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] v,
                                                     logic [RADIX_W-1:0] hi);
    logic [RADIX_W-1:0] r;
    r = v;
    if (v == '0) r = RADIX_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### hdl/fpam_div.sv
// pipelined restoring divider, a few quotient bits per stage, with sideband
// depends on fpam_pkg for the number of bits per stage
module fpam_div #(
  parameter int W  = 39,
  parameter int DW = 17,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quot_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  localparam int S  = fpam_pkg::DIV_STEP;
  localparam int N  = (W + S - 1) / S;
  localparam int PW = N * S;

  logic          v_q [N];
  logic [PW-1:0] x_q [N];
  logic [DW-1:0] r_q [N];
  logic [SW-1:0] s_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic          v_in;
    logic [PW-1:0] x_in, x_nx;
    logic [DW-1:0] r_in, r_nx;
    logic [SW-1:0] s_in;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = PW'(dividend_i);
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign x_in = x_q[g-1];
      assign r_in = r_q[g-1];
      assign s_in = s_q[g-1];
    end

    // shift in dividend bits msb first, subtract where the divisor fits
    always_comb begin
      logic [DW:0] t;
      x_nx = x_in;
      r_nx = r_in;
      t    = '0;
      for (int j = 0; j < S; j++) begin
        t    = {r_nx, x_nx[PW-1]};
        x_nx = {x_nx[PW-2:0], 1'b0};
        if (t >= {1'b0, divisor_i}) begin
          t       = t - {1'b0, divisor_i};
          x_nx[0] = 1'b1;
        end
        r_nx = t[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[g] <= 1'b0;
      else if (en_i) v_q[g] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g] <= x_nx;
        r_q[g] <= r_nx;
        s_q[g] <= s_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quot_o  = x_q[N-1][W-1:0];
  assign rem_o   = r_q[N-1];
  assign side_o  = s_q[N-1];

endmodule

### hdl/flash_page_address_mapper.sv
// top level of the flash page address mapper: config registers, digit chain
// depends on fpam_pkg and fpam_div
//
// usage
//   s_axis carries one logical page number per request; m_axis returns one
//   result per request: stack, die, plane, block, page and data port in
//   tdata, the beyond-capacity flag in tuser. registers are to be written over
//   the apb port only while no request is in flight; the block does not enforce it.
//   the page is split into mixed-radix digits by a chain of five pipelined
//   dividers (two quotient bits per stage), a multiply stage and an add stage
//   for the burst stripe policy, two stages for the flat plane index and a
//   small divider for the port modulo.
//   the digit dividers are XW bits wide, XW the capacity width (39 bits with
//   default limits); throughput is one request per cycle while the receiver is ready.
//   the divider chain depth dominates the latency; every stage takes a new
//   request each cycle unless the pipeline stalls.
//   reset clears all valid bits and loads mode linear and all geometry
//   registers with one.
//   when the receiver stalls, the whole pipeline holds and s_axis_tready_o
//   drops; nothing is lost or repeated.
module flash_page_address_mapper #(
  parameter int MAX_STACKS = fpam_pkg::MAX_STACKS_DEF,
  parameter int MAX_BLOCKS = fpam_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_PAGES  = fpam_pkg::MAX_PAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // logical_page
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // stack, die, plane, block, page, port, zero pad
  output logic [0:0]  m_axis_tuser_o,   // beyond_capacity
  // config port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [fpam_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int RW    = fpam_pkg::RADIX_W;
  localparam int ST_HI = (MAX_STACKS > 31) ? 31 : MAX_STACKS;
  localparam int BL_HI = (MAX_BLOCKS > 131071) ? 131071 : MAX_BLOCKS;
  localparam int PG_HI = (MAX_PAGES > 8191) ? 8191 : MAX_PAGES;
  localparam int CAP_BITS = $clog2(ST_HI) + 4 + 3 + $clog2(BL_HI) + $clog2(PG_HI);
  localparam int XW0 = (CAP_BITS > fpam_pkg::LPN_W) ? fpam_pkg::LPN_W : CAP_BITS;
  localparam int XW  = (XW0 < 1) ? 1 : XW0;
  localparam int SW  = $bits(fpam_pkg::side_t);
  localparam int LW  = $bits(fpam_pkg::loc_t);

  // config registers
  logic [1:0]  mode_q;
  logic [4:0]  stacks_q, dies_q, ports_q;
  logic [3:0]  planes_q;
  logic [16:0] blocks_q;
  logic [12:0] pages_q;
  logic [6:0]  slices_q;
  logic        wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= fpam_pkg::MODE_LINEAR;
      stacks_q <= 5'd1;
      dies_q   <= 5'd1;
      planes_q <= 4'd1;
      blocks_q <= 17'd1;
      pages_q  <= 13'd1;
      ports_q  <= 5'd1;
      slices_q <= 7'd1;
    end else if (wr_en) begin
      case (fpam_pkg::reg_e'(paddr_i[4:2]))
        fpam_pkg::REG_MODE:   mode_q   <= pwdata_i[1:0];
        fpam_pkg::REG_STACKS: stacks_q <= pwdata_i[4:0];
        fpam_pkg::REG_DIES:   dies_q   <= pwdata_i[4:0];
        fpam_pkg::REG_PLANES: planes_q <= pwdata_i[3:0];
        fpam_pkg::REG_BLOCKS: blocks_q <= pwdata_i[16:0];
        fpam_pkg::REG_PAGES:  pages_q  <= pwdata_i[12:0];
        fpam_pkg::REG_PORTS:  ports_q  <= pwdata_i[4:0];
        fpam_pkg::REG_SLICES: slices_q <= pwdata_i[6:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (fpam_pkg::reg_e'(paddr_i[4:2]))
      fpam_pkg::REG_MODE:   prdata_o = 32'(mode_q);
      fpam_pkg::REG_STACKS: prdata_o = 32'(stacks_q);
      fpam_pkg::REG_DIES:   prdata_o = 32'(dies_q);
      fpam_pkg::REG_PLANES: prdata_o = 32'(planes_q);
      fpam_pkg::REG_BLOCKS: prdata_o = 32'(blocks_q);
      fpam_pkg::REG_PAGES:  prdata_o = 32'(pages_q);
      fpam_pkg::REG_PORTS:  prdata_o = 32'(ports_q);
      fpam_pkg::REG_SLICES: prdata_o = 32'(slices_q);
      default:              prdata_o = '0;
    endcase
  end

  // clamped geometry
  logic [RW-1:0] ns, nd, np, nb, ng, nport, nsl;
  assign ns    = fpam_pkg::clamp_radix(RW'(stacks_q), RW'(ST_HI));
  assign nd    = fpam_pkg::clamp_radix(RW'(dies_q),   RW'(16));
  assign np    = fpam_pkg::clamp_radix(RW'(planes_q), RW'(8));
  assign nb    = fpam_pkg::clamp_radix(blocks_q,      RW'(BL_HI));
  assign ng    = fpam_pkg::clamp_radix(RW'(pages_q),  RW'(PG_HI));
  assign nport = fpam_pkg::clamp_radix(RW'(ports_q),  RW'(16));
  assign nsl   = fpam_pkg::clamp_radix(RW'(slices_q), RW'(64));

  // capacity, built from the clamped geometry through registered products
  logic [9:0]  cap_sd_q;
  logic [29:0] cap_bg_q;
  logic [13:0] cap_sdp_q;
  logic [29:0] cap_bg2_q;
  logic [43:0] cap_q;

  always_ff @(posedge clk_i) begin
    cap_sd_q  <= 10'(ns[4:0]) * 10'(nd[4:0]);
    cap_bg_q  <= 30'(nb) * 30'(ng[12:0]);
    cap_sdp_q <= 14'(cap_sd_q) * 14'(np[3:0]);
    cap_bg2_q <= cap_bg_q;
    cap_q     <= 44'(cap_sdp_q) * 44'(cap_bg2_q);
  end

  // radix of each digit slot by policy
  fpam_pkg::mode_e mode;
  logic [RW-1:0]   rad1, rad2, rad3, rad4, rad5;
  logic            burst;
  assign mode  = fpam_pkg::mode_e'(mode_q);
  assign burst = (mode == fpam_pkg::MODE_BURST);

  always_comb begin
    case (mode)
      fpam_pkg::MODE_LINEAR: begin
        rad1 = ng; rad2 = nb; rad3 = np; rad4 = nd; rad5 = RW'(1);
      end
      fpam_pkg::MODE_BURST: begin
        rad1 = nsl; rad2 = ns; rad3 = np; rad4 = nd; rad5 = ng;
      end
      default: begin
        rad1 = np; rad2 = nd; rad3 = ns; rad4 = ng; rad5 = RW'(1);
      end
    endcase
  end

  // pipeline advance
  logic out_valid_q;
  logic en;
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // first two digits
  fpam_pkg::side_t sd0, sd1, sd1m, sd2, sd2m;
  logic            v1, v2;
  logic [XW-1:0]   q1, q2;
  logic [RW-1:0]   rm1, rm2;

  always_comb begin
    sd0     = '0;
    sd0.lpn = s_axis_tdata_i;
  end

  fpam_div #(.W(XW), .DW(RW), .SW(SW)) u_div1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid_i),
    .dividend_i(s_axis_tdata_i[XW-1:0]), .divisor_i(rad1), .side_i(sd0),
    .valid_o(v1), .quot_o(q1), .rem_o(rm1), .side_o(sd1)
  );

  always_comb begin
    sd1m    = sd1;
    sd1m.r1 = rm1;
  end

  fpam_div #(.W(XW), .DW(RW), .SW(SW)) u_div2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .dividend_i(q1), .divisor_i(rad2), .side_i(sd1m),
    .valid_o(v2), .quot_o(q2), .rem_o(rm2), .side_o(sd2)
  );

  always_comb begin
    sd2m    = sd2;
    sd2m.r2 = rm2;
  end

  // burst stripe: w = quotient * slices + slice, multiply then add; other modes pass the quotient
  logic            m_vld_q, a_vld_q;
  logic [XW+6:0]   m_prod_q;
  logic [XW-1:0]   m_q_q, a_w_q;
  fpam_pkg::side_t m_side_q, a_side_q;
  logic [XW+6:0]   w_sum;

  assign w_sum = m_prod_q + (XW+7)'(m_side_q.r1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= v2;
      a_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_prod_q <= (XW+7)'(q2) * (XW+7)'(nsl[6:0]);
      m_q_q    <= q2;
      m_side_q <= sd2m;
      a_w_q    <= burst ? w_sum[XW-1:0] : m_q_q;
      a_side_q <= m_side_q;
    end
  end

  // last three digits
  fpam_pkg::side_t sd3, sd3m, sd4, sd4m, sd5;
  logic            v3, v4, v5;
  logic [XW-1:0]   q3, q4, q5;
  logic [RW-1:0]   rm3, rm4, rm5;

  fpam_div #(.W(XW), .DW(RW), .SW(SW)) u_div3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_vld_q),
    .dividend_i(a_w_q), .divisor_i(rad3), .side_i(a_side_q),
    .valid_o(v3), .quot_o(q3), .rem_o(rm3), .side_o(sd3)
  );

  always_comb begin
    sd3m    = sd3;
    sd3m.r3 = rm3;
  end

  fpam_div #(.W(XW), .DW(RW), .SW(SW)) u_div4 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3),
    .dividend_i(q3), .divisor_i(rad4), .side_i(sd3m),
    .valid_o(v4), .quot_o(q4), .rem_o(rm4), .side_o(sd4)
  );

  always_comb begin
    sd4m    = sd4;
    sd4m.r4 = rm4;
  end

  fpam_div #(.W(XW), .DW(RW), .SW(SW)) u_div5 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4),
    .dividend_i(q4), .divisor_i(rad5), .side_i(sd4m),
    .valid_o(v5), .quot_o(q5), .rem_o(rm5), .side_o(sd5)
  );

  // digits to location by policy
  fpam_pkg::loc_t loc;
  always_comb begin
    loc     = '0;
    loc.lpn = sd5.lpn;
    case (mode)
      fpam_pkg::MODE_LINEAR: begin
        loc.pg = sd5.r1[11:0];
        loc.bl = sd5.r2[15:0];
        loc.pl = sd5.r3[2:0];
        loc.di = sd5.r4[3:0];
        loc.st = q5[3:0];
      end
      fpam_pkg::MODE_BURST: begin
        loc.st = sd5.r2[3:0];
        loc.pl = sd5.r3[2:0];
        loc.di = sd5.r4[3:0];
        loc.pg = rm5[11:0];
        loc.bl = q5[15:0];
      end
      default: begin
        loc.pl = sd5.r1[2:0];
        loc.di = sd5.r2[3:0];
        loc.st = sd5.r3[3:0];
        loc.pg = sd5.r4[11:0];
        loc.bl = q5[15:0];
      end
    endcase
  end

  // flat plane index in two steps
  logic           f1_vld_q, f2_vld_q;
  logic [8:0]     f1_sd_q;
  logic [fpam_pkg::FLAT_W-1:0] f2_flat_q;
  fpam_pkg::loc_t f1_loc_q, f2_loc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= v5;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_sd_q   <= 9'(loc.st) * 9'(nd[4:0]) + 9'(loc.di);
      f1_loc_q  <= loc;
      f2_flat_q <= fpam_pkg::FLAT_W'(f1_sd_q) * fpam_pkg::FLAT_W'(np[3:0])
                   + fpam_pkg::FLAT_W'(f1_loc_q.pl);
      f2_loc_q  <= f1_loc_q;
    end
  end

  // port modulo
  logic           vp;
  logic [fpam_pkg::FLAT_W-1:0]  qp;
  logic [fpam_pkg::NPORT_W-1:0] rmp;
  fpam_pkg::loc_t lp;
  logic [LW-1:0]  lp_vec;

  fpam_div #(.W(fpam_pkg::FLAT_W), .DW(fpam_pkg::NPORT_W), .SW(LW)) u_divp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f2_vld_q),
    .dividend_i(f2_flat_q), .divisor_i(nport[4:0]), .side_i(f2_loc_q),
    .valid_o(vp), .quot_o(qp), .rem_o(rmp), .side_o(lp_vec)
  );

  assign lp = lp_vec;

  // output register with capacity check
  logic        beyond;
  logic [47:0] out_data_q;
  logic        out_user_q;
  assign beyond = (lp.lpn >= 48'(cap_q)) || (qp > fpam_pkg::FLAT_W'(2047));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vp;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_user_q <= beyond;
      if (beyond) out_data_q <= '0;
      else out_data_q <= {5'd0, rmp[3:0], lp.pg, lp.bl, lp.pl, lp.di, lp.st};
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_user_q;

  // an out-of-capacity result carries a zero address
  a_beyond_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("beyond-capacity result with nonzero address");

  // port index stays below the clamped port count
  a_port_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 5'(m_axis_tdata_o[42:39]) < nport[4:0])
    else $error("port index out of range");

  // a stalled pipeline holds the valid bits of its last stages
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vp) && $stable(f2_vld_q) && $stable(v5))
    else $error("pipeline moved while stalled");

endmodule
